>>> hdl/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and constants of the sorted array priority queue: field
// widths, action and status codes, controller states, command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sapq_pkg;

   localparam int DATA_W        = 32;
   localparam int COUNT_W       = 4;
   localparam int DEPTH_DEFAULT = 8;

   // request action codes
   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_DELETE = 1'b1
   } action_type;

   // result status codes
   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_OVERFLOW  = 2'd1,
      STS_EMPTY     = 2'd2,
      STS_NOT_FOUND = 2'd3
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_RESP = 2'd2
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       do_insert;
      logic       do_delete;
      logic       load_rsp;
      status_type code;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_delete;
      logic full;
      logic empty;
      logic found;
   } sts_type;

endpackage

>>> hdl/sapq_ctrl.sv
// ----------------------------------------------------------------------------
// sapq_ctrl
// Controller of the queue: runs the request and result handshakes, picks
// the status of each operation and tells the datapath when to commit it.
// ----------------------------------------------------------------------------
module sapq_ctrl
   import sapq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd           = '0;
      cmd.code      = STS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.load_rsp = 1'b1;
            if (!sts.is_delete) begin
               // insert fails only when every slot is taken
               if (sts.full) begin
                  cmd.code = STS_OVERFLOW;
               end else begin
                  cmd.do_insert = 1'b1;
               end
            end else begin
               if (sts.empty) begin
                  cmd.code = STS_EMPTY;
               end else if (!sts.found) begin
                  cmd.code = STS_NOT_FOUND;
               end else begin
                  cmd.do_delete = 1'b1;
               end
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

>>> hdl/sapq_datapath.sv
// ----------------------------------------------------------------------------
// sapq_datapath
// Sorted register array with its own compares in every slot. Each slot decides on its
// own whether it keeps its value, takes the new value or takes a neighbor,
// so an insert or delete commits to all slots at once.
// ----------------------------------------------------------------------------
module sapq_datapath
   import sapq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_action,
   input  logic signed [DATA_W-1:0] req_value,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   output logic [1:0]               rsp_status,
   output logic [COUNT_W-1:0]       rsp_count,
   output logic signed [DATA_W-1:0] rsp_top_value
);

   localparam int CountW = $clog2(DEPTH + 1);

   logic                     act_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic [CountW-1:0]        count_ff;
   logic [CountW-1:0]        count_in;
   status_type               status_ff;
   logic signed [DATA_W-1:0] entry_ff [DEPTH];

   logic [DEPTH-1:0] slot_valid;
   logic [DEPTH-1:0] ins_at;
   logic [DEPTH-1:0] del_at;
   logic [DEPTH-1:0] match;
   logic [CountW+COUNT_W-1:0] count_ext;

   // request capture, payload only
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         val_ff <= req_value;
      end
   end

   // status of the last operation
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff <= cmd.code;
      end
   end

   // per-slot compare
   for (genvar g = 0; g < DEPTH; g++) begin : g_cmp
      assign slot_valid[g] = count_ff > CountW'(g);
      assign match[g]      = slot_valid[g] && (entry_ff[g] == val_ff);
      // sorted descending, so ins_at holds on a suffix of the slots, del_at on a suffix of the valid slots
      assign ins_at[g]     = !slot_valid[g] || (val_ff >= entry_ff[g]);
      assign del_at[g]     = entry_ff[g] <= val_ff;
   end

   // slot update
   for (genvar g = 0; g < DEPTH; g++) begin : g_slot
      logic signed [DATA_W-1:0] from_prev;
      logic signed [DATA_W-1:0] from_next;
      if (g == 0) begin : g_first
         assign from_prev = val_ff;
      end else begin : g_mid
         assign from_prev = ins_at[g-1] ? entry_ff[g-1] : val_ff;
      end
      if (g == DEPTH - 1) begin : g_last
         assign from_next = entry_ff[g];
      end else begin : g_inner
         assign from_next = entry_ff[g+1];
      end
      always_ff @(posedge clock) begin
         if (cmd.do_insert && ins_at[g]) begin
            entry_ff[g] <= from_prev;
         end else if (cmd.do_delete && del_at[g]) begin
            entry_ff[g] <= from_next;
         end
      end
   end

   // fill count
   always_comb begin
      count_in = count_ff;
      if (cmd.do_insert) begin
         count_in = count_ff + CountW'(1);
      end else if (cmd.do_delete) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // flags for the controller
   assign sts.is_delete = act_ff == ACT_DELETE;
   assign sts.full      = count_ff == CountW'(DEPTH);
   assign sts.empty     = count_ff == '0;
   assign sts.found     = |match;

   // result fields, stable while the result beat waits
   assign count_ext     = {{COUNT_W{1'b0}}, count_ff};
   assign rsp_status    = status_ff;
   assign rsp_count     = count_ext[COUNT_W-1:0];
   assign rsp_top_value = (count_ff == '0) ? '0 : entry_ff[0];

endmodule

>>> hdl/sorted_array_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_unit
// Priority queue of signed values kept in descending order in a register
// array; insert and delete by value, one result beat per request beat.
// ----------------------------------------------------------------------------
//  channel  | ports                               | direction
//  ---------+-------------------------------------+----------
//  request  | req_valid/ready, action, value      | in
//  result   | rsp_valid/ready, status, count, top | out
//
//  an item goes through accept, commit to the array, result beat
//  the commit compares every slot in parallel in the EXEC state
//  a new request is taken only after the previous result beat is accepted
//  rsp_ready low holds the result and the array unchanged
//  reset clears the count; the stored values are not cleared
module sorted_array_priority_queue_unit
   import sapq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_action,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [COUNT_W-1:0]       rsp_count,
   output logic signed [DATA_W-1:0] rsp_top_value
);

   cmd_type cmd;
   sts_type sts;

   // sequencing and handshakes
   sapq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // sorted array and result fields
   sapq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_action    (req_action),
      .req_value     (req_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .rsp_top_value (rsp_top_value)
   );

endmodule

>>> hdl/sapq_checker.sv
// ----------------------------------------------------------------------------
// sapq_checker
// Port-level checks of the queue: result hold under stall, one request at
// a time, and consistency between status, count and top value.
// ----------------------------------------------------------------------------
module sapq_checker
   import sapq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [1:0]               rsp_status,
   input logic [COUNT_W-1:0]       rsp_count,
   input logic signed [DATA_W-1:0] rsp_top_value
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_count) && $stable(rsp_top_value))
      else $error("result beat changed while stalled");

   // no second request before the result of the first
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while one is in flight");

   // empty store shows zero on top
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count == '0 && DEPTH < 16 |-> rsp_top_value == '0)
      else $error("empty store with nonzero top value");

   // overflow only when full
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_OVERFLOW |-> rsp_count == COUNT_W'(DEPTH))
      else $error("overflow reported below capacity");

   // empty status only with zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_EMPTY |-> rsp_count == '0)
      else $error("empty reported with entries stored");

endmodule

bind sorted_array_priority_queue_unit sapq_checker #(.DEPTH(DEPTH)) u_sapq_checker (.*);

>>> tb/sorted_array_priority_queue_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_unit_tb
// Self-checking bench for the sorted array priority queue. A shadow copy of
// the descending store predicts status, count and top value for every
// request beat. Result beats are compared in order against that prediction
// while both channels idle and stall at random outside the calm stretch.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_unit_tb;
   import sapq_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int RAND_ITEMS  = 1250;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 12;

   // one predicted result beat
   typedef struct {
      status_type               status;
      logic [COUNT_W-1:0]       count;
      logic signed [DATA_W-1:0] top;
   } pq_result_type;

   // shadow queue plus the in-order store of predicted results
   class pq_result_board;
      logic signed [DATA_W-1:0] held_vals [DEPTH];
      int                       held_count;
      pq_result_type            awaited [$];
      int                       mismatches;

      function new();
         held_count = 0;
         mismatches = 0;
      endfunction

      // apply one accepted request to the shadow queue and predict its result
      function void note_request(action_type act, logic signed [DATA_W-1:0] val);
         pq_result_type r;
         int            pos;
         pos = 0;
         r.status = STS_OK;
         if (act == ACT_INSERT) begin
            if (held_count >= DEPTH) begin
               r.status = STS_OVERFLOW;
            end else begin
               // new value goes ahead of the first entry less than or equal to it
               while (pos < held_count && val < held_vals[pos]) pos++;
               for (int j = held_count; j > pos; j--) held_vals[j] = held_vals[j-1];
               held_vals[pos] = val;
               held_count++;
            end
         end else begin
            if (held_count == 0) begin
               r.status = STS_EMPTY;
            end else begin
               while (pos < held_count && held_vals[pos] != val) pos++;
               if (pos >= held_count) begin
                  r.status = STS_NOT_FOUND;
               end else begin
                  for (int j = pos; j + 1 < held_count; j++) held_vals[j] = held_vals[j+1];
                  held_count--;
               end
            end
         end
         r.count = held_count[COUNT_W-1:0];
         r.top   = (held_count > 0) ? held_vals[0] : '0;
         awaited.push_back(r);
      endfunction

      // compare one result beat against the oldest prediction
      function void check_result(logic [1:0] st, logic [COUNT_W-1:0] cnt,
                                 logic signed [DATA_W-1:0] top);
         pq_result_type r;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: status %0d count %0d top %0d",
                        st, cnt, top);
            return;
         end
         r = awaited.pop_front();
         if (st !== r.status || cnt !== r.count || top !== r.top) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp st %0d cnt %0d top %0d, got st %0d cnt %0d top %0d",
                        r.status, r.count, r.top, st, cnt, top);
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                     clock         = 1'b0;
   logic                     reset         = 1'b1;
   logic                     req_valid     = 1'b0;
   logic                     req_ready;
   logic                     req_action    = 1'b0;
   logic signed [DATA_W-1:0] req_value     = '0;
   logic                     rsp_valid;
   logic                     rsp_ready     = 1'b1;
   logic [1:0]               rsp_status;
   logic [COUNT_W-1:0]       rsp_count;
   logic signed [DATA_W-1:0] rsp_top_value;

   pq_result_board board = new();
   bit             calm_stretch = 1'b0;
   int             cycle_count  = 0;

   sorted_array_priority_queue_unit #(.DEPTH(DEPTH)) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .rsp_top_value (rsp_top_value)
   );

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: check beats, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         board.check_result(rsp_status, rsp_count, rsp_top_value);
      rsp_ready <= calm_stretch || ($urandom_range(99) >= 24);
   end

   // one request beat, with a random idle gap ahead of it
   task automatic send_beat(input action_type act, input logic signed [DATA_W-1:0] val);
      while (!calm_stretch && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= val;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.note_request(act, val);
   endtask

   // value mix: narrow pool for duplicates, extremes, full range
   function automatic logic signed [DATA_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40)
         return $signed(DATA_W'($urandom_range(7))) - 4;
      else if (roll < 50)
         case ($urandom_range(3))
            0:       return {1'b0, {(DATA_W-1){1'b1}}};
            1:       return {1'b1, {(DATA_W-1){1'b0}}};
            2:       return '0;
            default: return '1;
         endcase
      else
         return $signed($urandom());
   endfunction

   task automatic send_random(input int idx);
      int         insert_pct;
      action_type act;
      logic signed [DATA_W-1:0] val;
      // phases of filling, draining and balanced traffic
      case ((idx / 100) % 3)
         0:       insert_pct = 80;
         1:       insert_pct = 20;
         default: insert_pct = 50;
      endcase
      act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_DELETE;
      val = pick_value();
      // most deletes hit a stored value
      if (act == ACT_DELETE && board.held_count > 0 && $urandom_range(99) < 65)
         val = board.held_vals[$urandom_range(board.held_count - 1)];
      send_beat(act, val);
   endtask

   // stimulus
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // delete from an empty store
      send_beat(ACT_DELETE, 7);
      // largest, then smallest goes behind everything
      send_beat(ACT_INSERT, {1'b0, {(DATA_W-1){1'b1}}});
      send_beat(ACT_INSERT, {1'b1, {(DATA_W-1){1'b0}}});
      // equal values
      send_beat(ACT_INSERT, 5);
      send_beat(ACT_INSERT, 5);
      send_beat(ACT_INSERT, -1);
      // absent value
      send_beat(ACT_DELETE, 12345);
      send_beat(ACT_INSERT, 0);
      send_beat(ACT_INSERT, {1'b0, {(DATA_W-1){1'b1}}});
      send_beat(ACT_INSERT, -2);
      // full store overflows
      send_beat(ACT_INSERT, 9);
      // drain in mixed order
      send_beat(ACT_DELETE, {1'b0, {(DATA_W-1){1'b1}}});
      send_beat(ACT_DELETE, {1'b1, {(DATA_W-1){1'b0}}});
      send_beat(ACT_DELETE, 5);
      send_beat(ACT_DELETE, -1);
      send_beat(ACT_DELETE, 0);
      send_beat(ACT_DELETE, 5);
      send_beat(ACT_DELETE, {1'b0, {(DATA_W-1){1'b1}}});
      send_beat(ACT_DELETE, -2);
      send_beat(ACT_DELETE, -2);

      for (int i = 0; i < RAND_ITEMS; i++) begin
         calm_stretch = (i >= 300 && i < 550);
         // hold off until the queue of results runs dry
         if (i == 700) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (board.pending() != 0);
         end
         send_random(i);
      end
      calm_stretch = 1'b0;
      req_valid <= 1'b0;

      // drain
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> sim.f
hdl/sapq_pkg.sv
hdl/sapq_ctrl.sv
hdl/sapq_datapath.sv
hdl/sorted_array_priority_queue_unit.sv
hdl/sapq_checker.sv
tb/sorted_array_priority_queue_unit_tb.sv
